[rtl/lgf_pkg.sv]
// ----------------------------------------------------------------------------
// lgf_pkg
// shared types and constants of the gap follow steering unit
// ----------------------------------------------------------------------------
`default_nettype none

package lgf_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int LEN_W       = IDX_W + 1;
  localparam int SPAN_W      = LEN_W + 1;
  localparam int RANGE_W     = 16;
  localparam int DEG_W       = 16;
  localparam int GAIN_W      = 24;
  localparam int CAP_W       = 31;
  localparam int CFG_W       = 31;
  localparam int CFG_IDX_W   = 3;
  localparam int CENTER_W    = 17;
  localparam int ERR_W       = CENTER_W + 1;
  localparam int INT_W       = 32;
  localparam int STEER_W     = 32;
  localparam int PRODC_W     = SPAN_W + DEG_W;
  localparam int PRODP_W     = GAIN_W + 1 + ERR_W;
  localparam int PRODI_W     = GAIN_W + 1 + INT_W;
  localparam int ACC_W       = PRODI_W + 1;
  localparam int CSHIFT      = 9;
  localparam int PSHIFT      = 16;

  localparam logic [IDX_W-1:0]    LAST_IDX   = IDX_W'(MAX_SAMPLES - 1);
  localparam logic [CENTER_W-1:0] CENTER_MAX = CENTER_W'(92160);
  localparam logic [CENTER_W-1:0] NINETY_Q8  = CENTER_W'(23040);

  localparam logic [RANGE_W-1:0] NEAR_RST  = RANGE_W'(500);
  localparam logic [RANGE_W-1:0] FAR_RST   = RANGE_W'(1000);
  localparam logic [LEN_W-1:0]   FIRST_RST = LEN_W'(140);
  localparam logic [LEN_W-1:0]   LATER_RST = LEN_W'(70);
  localparam logic [DEG_W-1:0]   DEG_RST   = DEG_W'(16384);
  localparam logic [GAIN_W-1:0]  KP_RST    = GAIN_W'(167772);
  localparam logic [GAIN_W-1:0]  KI_RST    = GAIN_W'(1678);
  localparam logic [CAP_W-1:0]   CAP_RST   = CAP_W'(77);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEAR_LIMIT  = 3'd0,
    REG_FAR_LIMIT   = 3'd1,
    REG_FIRST_MIN   = 3'd2,
    REG_LATER_MIN   = 3'd3,
    REG_DEG_PER_SMP = 3'd4,
    REG_PROP_GAIN   = 3'd5,
    REG_INT_GAIN    = 3'd6,
    REG_INT_CAP     = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_SCAN,
    S_CMUL,
    S_SMOOTH,
    S_INTEG,
    S_PIMUL,
    S_OUT
  } state_t;

  typedef struct packed {
    logic take_sample;
    logic center_mul;
    logic smooth;
    logic integ;
    logic pi_mul;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

[rtl/lgf_ctrl.sv]
// ----------------------------------------------------------------------------
// lgf_ctrl
// sequencer: sample intake and the scan end steps
// ----------------------------------------------------------------------------
`default_nettype none

module lgf_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire lgf_pkg::status_t status,
  output lgf_pkg::cmd_t        cmd
);
  import lgf_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   take;

  assign take = in_valid && (state_r == S_SCAN);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_SCAN: begin
        if (take && status.scan_end) state_nxt = S_CMUL;
      end
      S_CMUL:   state_nxt = S_SMOOTH;
      S_SMOOTH: state_nxt = S_INTEG;
      S_INTEG:  state_nxt = S_PIMUL;
      S_PIMUL:  state_nxt = S_OUT;
      S_OUT: begin
        if (status.out_free) state_nxt = S_SCAN;
      end
      default: state_nxt = S_SCAN;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_SCAN: begin
        in_ready         = 1'b1;
        cmd.take_sample  = take;
      end
      S_CMUL:   cmd.center_mul = 1'b1;
      S_SMOOTH: cmd.smooth     = 1'b1;
      S_INTEG:  cmd.integ      = 1'b1;
      S_PIMUL:  cmd.pi_mul     = 1'b1;
      S_OUT:    cmd.load_out   = status.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SCAN;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/lgf_dp.sv]
// ----------------------------------------------------------------------------
// lgf_dp
// datapath: registers, run tracking, center smoothing and pi steering math
// ----------------------------------------------------------------------------
`default_nettype none

module lgf_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [lgf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lgf_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire logic [lgf_pkg::RANGE_W-1:0]     in_range_mm,
  input  wire logic                            in_last_sample,
  input  wire lgf_pkg::cmd_t                   cmd,
  output lgf_pkg::status_t                     status,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic signed [lgf_pkg::STEER_W-1:0]   out_steer_rate,
  output logic [lgf_pkg::CENTER_W-1:0]         out_gap_center,
  output logic                                 out_gap_found
);
  import lgf_pkg::*;

  // configuration
  logic [RANGE_W-1:0] near_r, far_r;
  logic [LEN_W-1:0]   first_min_r, later_min_r;
  logic [DEG_W-1:0]   deg_r;
  logic [GAIN_W-1:0]  kp_r, ki_r;
  logic [CAP_W-1:0]   cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r      <= NEAR_RST;
      far_r       <= FAR_RST;
      first_min_r <= FIRST_RST;
      later_min_r <= LATER_RST;
      deg_r       <= DEG_RST;
      kp_r        <= KP_RST;
      ki_r        <= KI_RST;
      cap_r       <= CAP_RST;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_NEAR_LIMIT:  near_r      <= cfg_wdata[RANGE_W-1:0];
        REG_FAR_LIMIT:   far_r       <= cfg_wdata[RANGE_W-1:0];
        REG_FIRST_MIN:   first_min_r <= cfg_wdata[LEN_W-1:0];
        REG_LATER_MIN:   later_min_r <= cfg_wdata[LEN_W-1:0];
        REG_DEG_PER_SMP: deg_r       <= cfg_wdata[DEG_W-1:0];
        REG_PROP_GAIN:   kp_r        <= cfg_wdata[GAIN_W-1:0];
        REG_INT_GAIN:    ki_r        <= cfg_wdata[GAIN_W-1:0];
        REG_INT_CAP:     cap_r       <= cfg_wdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // per-scan run tracking
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              in_gap_r, in_gap_nxt;
  logic [IDX_W-1:0]  run_start_r, run_start_nxt;
  logic [LEN_W-1:0]  run_len_r, run_len_nxt;
  logic [LEN_W-1:0]  best_len_r, best_len_nxt;
  logic [IDX_W-1:0]  best_start_r, best_start_nxt;
  logic              found_r, found_nxt;
  logic              first_scan_r, first_scan_nxt;
  logic [SPAN_W-1:0] span_r, span_nxt;
  logic              scan_found_r, scan_found_nxt;

  logic              scan_end, in_band, obstacle, opening, gap_now, closing, qualify;
  logic [LEN_W-1:0]  run_len_upd, bar;
  logic [IDX_W-1:0]  run_start_upd, best_start_upd;
  logic [LEN_W-1:0]  best_len_upd;
  logic              found_upd;

  always_comb begin
    scan_end      = in_last_sample || (idx_r == LAST_IDX);
    in_band       = (in_range_mm > near_r) && (in_range_mm < far_r);
    obstacle      = (idx_r == '0) || scan_end || in_band;
    opening       = !obstacle && !in_gap_r;
    gap_now       = in_gap_r || opening;
    run_start_upd = opening ? idx_r : run_start_r;
    run_len_upd   = run_len_r;
    if (gap_now) run_len_upd = (opening ? '0 : run_len_r) + LEN_W'(1);
    closing        = obstacle && gap_now;
    bar            = found_r ? best_len_r : (first_scan_r ? first_min_r : later_min_r);
    qualify        = closing && (run_len_upd > bar);
    best_start_upd = qualify ? run_start_upd : best_start_r;
    best_len_upd   = qualify ? run_len_upd : best_len_r;
    found_upd      = found_r || qualify;

    idx_nxt        = idx_r;
    in_gap_nxt     = in_gap_r;
    run_start_nxt  = run_start_r;
    run_len_nxt    = run_len_r;
    best_len_nxt   = best_len_r;
    best_start_nxt = best_start_r;
    found_nxt      = found_r;
    first_scan_nxt = first_scan_r;
    span_nxt       = span_r;
    scan_found_nxt = scan_found_r;
    if (cmd.take_sample) begin
      if (scan_end) begin
        span_nxt       = SPAN_W'({best_start_upd, 1'b0}) + SPAN_W'(best_len_upd);
        scan_found_nxt = found_upd;
        idx_nxt        = '0;
        in_gap_nxt     = 1'b0;
        run_start_nxt  = '0;
        run_len_nxt    = '0;
        found_nxt      = 1'b0;
        best_len_nxt   = later_min_r;
        best_start_nxt = best_start_upd;
        first_scan_nxt = 1'b0;
      end else begin
        idx_nxt        = idx_r + IDX_W'(1);
        in_gap_nxt     = closing ? 1'b0 : gap_now;
        run_start_nxt  = run_start_upd;
        run_len_nxt    = closing ? '0 : run_len_upd;
        best_len_nxt   = best_len_upd;
        best_start_nxt = best_start_upd;
        found_nxt      = found_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      in_gap_r     <= 1'b0;
      run_start_r  <= '0;
      run_len_r    <= '0;
      best_len_r   <= FIRST_RST;
      best_start_r <= '0;
      found_r      <= 1'b0;
      first_scan_r <= 1'b1;
      scan_found_r <= 1'b0;
    end else begin
      idx_r        <= idx_nxt;
      in_gap_r     <= in_gap_nxt;
      run_start_r  <= run_start_nxt;
      run_len_r    <= run_len_nxt;
      best_len_r   <= best_len_nxt;
      best_start_r <= best_start_nxt;
      found_r      <= found_nxt;
      first_scan_r <= first_scan_nxt;
      scan_found_r <= scan_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    span_r <= span_nxt;
  end

  // scan end math
  logic [PRODC_W-1:0]              prod_c_r;
  logic [CENTER_W-1:0]             smooth_r, smooth_nxt;
  logic signed [INT_W-1:0]         integ_r, integ_nxt;
  logic signed [ERR_W-1:0]         err_r;
  logic signed [PRODP_W-1:0]       prod_p_r;
  logic signed [PRODI_W-1:0]       prod_i_r;

  logic [PRODC_W-CSHIFT-1:0]       center_raw;
  logic [CENTER_W-1:0]             center_sat;
  logic [CENTER_W:0]               center_sum;
  logic signed [ERR_W-1:0]         err;
  logic signed [INT_W:0]           integ_sum;
  logic signed [ACC_W-1:0]         acc, acc_sh;
  logic signed [STEER_W-1:0]       steer;

  localparam logic signed [INT_W:0] INT_MIN33 = -(INT_W+1)'(64'sd1 <<< (INT_W-1));
  localparam logic signed [ACC_W-1:0] STEER_MAX = ACC_W'((64'sd1 <<< (STEER_W-1)) - 1);
  localparam logic signed [ACC_W-1:0] STEER_MIN = -ACC_W'(64'sd1 <<< (STEER_W-1));

  always_comb begin
    center_raw = prod_c_r[PRODC_W-1:CSHIFT];
    center_sat = (center_raw > (PRODC_W-CSHIFT)'(CENTER_MAX)) ? CENTER_MAX
                                                              : center_raw[CENTER_W-1:0];
    center_sum = (CENTER_W+1)'(center_sat) + (CENTER_W+1)'(smooth_r);
    smooth_nxt = smooth_r;
    if (cmd.smooth && scan_found_r) smooth_nxt = center_sum[CENTER_W:1];

    err       = $signed({1'b0, smooth_r}) - $signed({1'b0, NINETY_Q8});
    integ_sum = (INT_W+1)'(integ_r) + (INT_W+1)'(err);
    integ_nxt = integ_r;
    if (cmd.integ) begin
      if (integ_sum > $signed({2'b00, cap_r})) begin
        integ_nxt = $signed({1'b0, cap_r});
      end else if (integ_sum < INT_MIN33) begin
        integ_nxt = INT_MIN33[INT_W-1:0];
      end else begin
        integ_nxt = integ_sum[INT_W-1:0];
      end
    end

    acc    = ACC_W'(prod_p_r) + ACC_W'(prod_i_r);
    acc_sh = acc >>> PSHIFT;
    if (acc_sh > STEER_MAX) begin
      steer = STEER_MAX[STEER_W-1:0];
    end else if (acc_sh < STEER_MIN) begin
      steer = STEER_MIN[STEER_W-1:0];
    end else begin
      steer = acc_sh[STEER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= '0;
      integ_r  <= '0;
    end else begin
      smooth_r <= smooth_nxt;
      integ_r  <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.center_mul) prod_c_r <= span_r * deg_r;
    if (cmd.integ) err_r <= err;
    if (cmd.pi_mul) begin
      prod_p_r <= $signed({1'b0, kp_r}) * err_r;
      prod_i_r <= $signed({1'b0, ki_r}) * integ_r;
    end
  end

  // output word register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_steer_rate <= steer;
      out_gap_center <= smooth_r;
      out_gap_found  <= scan_found_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign status.scan_end = scan_end;
  assign status.out_free = !out_valid_r || out_ready;

endmodule

`default_nettype wire

[rtl/lidar_gap_follow_steering_unit.sv]
// ----------------------------------------------------------------------------
// lidar_gap_follow_steering_unit
// follow the gap steering: widest free run per scan, smoothed center, pi rate
//
//   channel  ports                                    word
//   in       in_valid / in_ready                      in_range_mm, in_last_sample
//   out      out_valid / out_ready                    out_steer_rate, out_gap_center,
//                                                     out_gap_found
//   cfg      cfg_wr_en, cfg_index, cfg_wdata          one register per write
//
// one sample word per cycle while a scan runs
// after the last sample of a scan the input waits through the center multiply,
// smoothing, integrator, two parallel pi multiplies, then the sum and saturation
// into the output register
// a held output word stalls the input only at the next scan end's final step
// reset is synchronous, active low, and restores the register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_gap_follow_steering_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [lgf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lgf_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [lgf_pkg::RANGE_W-1:0]     in_range_mm,
  input  wire logic                            in_last_sample,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [lgf_pkg::STEER_W-1:0]   out_steer_rate,
  output logic [lgf_pkg::CENTER_W-1:0]         out_gap_center,
  output logic                                 out_gap_found
);
  import lgf_pkg::*;

  cmd_t    cmd;
  status_t status;

  lgf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lgf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_range_mm    (in_range_mm),
    .in_last_sample (in_last_sample),
    .cmd            (cmd),
    .status         (status),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_steer_rate (out_steer_rate),
    .out_gap_center (out_gap_center),
    .out_gap_found  (out_gap_found)
  );

endmodule

`default_nettype wire

[test/lgf_steer_checker.sv]
// ----------------------------------------------------------------------------
// lgf_steer_checker
// watches the sample, steering and register ports of the gap follow unit,
// predicts each scan end steering word and compares it field by field
// ----------------------------------------------------------------------------
`default_nettype none

module lgf_steer_checker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [lgf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [lgf_pkg::CFG_W-1:0]           cfg_wdata,
  input  wire logic                                in_valid,
  input  wire logic                                in_ready,
  input  wire logic [lgf_pkg::RANGE_W-1:0]         in_range_mm,
  input  wire logic                                in_last_sample,
  input  wire logic                                out_valid,
  input  wire logic                                out_ready,
  input  wire logic signed [lgf_pkg::STEER_W-1:0]  out_steer_rate,
  input  wire logic [lgf_pkg::CENTER_W-1:0]        out_gap_center,
  input  wire logic                                out_gap_found,
  output int                                       fail_count,
  output int                                       pending,
  output int                                       checked
);

  timeunit 1ns;
  timeprecision 1ps;

  import lgf_pkg::*;

  localparam longint CENTER_SAT  = 92160;
  localparam longint RIGHT_ANGLE = 23040;
  localparam longint RATE_MAX    = 64'sd2147483647;
  localparam longint RATE_MIN    = -64'sd2147483648;

  typedef struct packed {
    logic signed [STEER_W-1:0] steer;
    logic [CENTER_W-1:0]       center;
    logic                      found;
  } steer_cmd_t;

  steer_cmd_t steer_cmd_q[$];

  logic [RANGE_W-1:0]  near_mm, far_mm;
  logic [LEN_W-1:0]    first_min, later_min;
  logic [DEG_W-1:0]    deg_step;
  logic [GAIN_W-1:0]   kp, ki;
  logic [CAP_W-1:0]    icap;

  logic [IDX_W-1:0]    idx, run_start, best_start;
  logic [LEN_W-1:0]    run_len, best_len;
  logic                in_run, have_gap, first_scan;
  logic [CENTER_W-1:0] center_avg;
  longint              err_sum;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  task automatic clear_scan();
    idx      = '0;
    in_run   = 1'b0;
    run_start = '0;
    run_len  = '0;
    have_gap = 1'b0;
  endtask

  task automatic reset_all();
    near_mm    = 16'd500;
    far_mm     = 16'd1000;
    first_min  = 13'd140;
    later_min  = 13'd70;
    deg_step   = 16'd16384;
    kp         = 24'd167772;
    ki         = 24'd1678;
    icap       = 31'd77;
    clear_scan();
    best_len   = first_min;
    best_start = '0;
    first_scan = 1'b1;
    center_avg = '0;
    err_sum    = 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] which, input logic [CFG_W-1:0] value);
    case (which)
      REG_NEAR_LIMIT:  near_mm   = value[RANGE_W-1:0];
      REG_FAR_LIMIT:   far_mm    = value[RANGE_W-1:0];
      REG_FIRST_MIN:   first_min = value[LEN_W-1:0];
      REG_LATER_MIN:   later_min = value[LEN_W-1:0];
      REG_DEG_PER_SMP: deg_step  = value[DEG_W-1:0];
      REG_PROP_GAIN:   kp        = value[GAIN_W-1:0];
      REG_INT_GAIN:    ki        = value[GAIN_W-1:0];
      REG_INT_CAP:     icap      = value[CAP_W-1:0];
      default: ;
    endcase
  endtask

  // one range sample through the gap tracker, scan end math on the last one
  task automatic follow_gap_step(input logic [RANGE_W-1:0] r, input logic last);
    logic       scan_end, obstacle;
    logic [LEN_W-1:0] bar;
    longint     span, err, acc, rate;
    steer_cmd_t cmd;
    scan_end = last || (idx == IDX_W'(MAX_SAMPLES - 1));
    obstacle = (idx == '0) || scan_end || (r > near_mm && r < far_mm);
    if (!obstacle && !in_run) begin
      in_run    = 1'b1;
      run_start = idx;
      run_len   = '0;
    end
    if (in_run) run_len = run_len + 1'b1;
    if (obstacle && in_run) begin
      bar = have_gap ? best_len : (first_scan ? first_min : later_min);
      if (run_len > bar) begin
        best_start = run_start;
        best_len   = run_len;
        have_gap   = 1'b1;
      end
      in_run  = 1'b0;
      run_len = '0;
    end
    if (!scan_end) begin
      idx = idx + 1'b1;
    end else begin
      if (have_gap) begin
        span = ((longint'(best_start) * 2 + longint'(best_len)) * longint'(deg_step)) >>> 9;
        if (span > CENTER_SAT) span = CENTER_SAT;
        center_avg = CENTER_W'((span + longint'(center_avg)) >>> 1);
      end
      err = longint'(center_avg) - RIGHT_ANGLE;
      err_sum = err_sum + err;
      if (err_sum > longint'(icap)) err_sum = longint'(icap);
      if (err_sum < RATE_MIN) err_sum = RATE_MIN;
      acc  = longint'(kp) * err + longint'(ki) * err_sum;
      rate = acc >>> 16;
      if (rate > RATE_MAX) rate = RATE_MAX;
      if (rate < RATE_MIN) rate = RATE_MIN;
      cmd.steer  = rate[STEER_W-1:0];
      cmd.center = center_avg;
      cmd.found  = have_gap;
      steer_cmd_q.push_back(cmd);
      clear_scan();
      best_len   = later_min;
      first_scan = 1'b0;
    end
  endtask

  task automatic check_steer_word();
    steer_cmd_t want;
    if (steer_cmd_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected steer word: rate %0d center %0d found %0b",
                 out_steer_rate, out_gap_center, out_gap_found);
    end else begin
      want = steer_cmd_q.pop_front();
      checked++;
      if (want.steer !== out_steer_rate || want.center !== out_gap_center ||
          want.found !== out_gap_found) begin
        fail_count++;
        if (fail_count <= 10)
          $display({"steer word %0d: expected rate %0d center %0d found %0b, ",
                    "got rate %0d center %0d found %0b"},
                   checked, $signed(want.steer), want.center, want.found,
                   out_steer_rate, out_gap_center, out_gap_found);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_all();
      steer_cmd_q.delete();
    end else begin
      if (cfg_wr_en) write_reg(cfg_index, cfg_wdata);
      if (out_valid && out_ready) check_steer_word();
      if (in_valid && in_ready) follow_gap_step(in_range_mm, in_last_sample);
    end
    pending = steer_cmd_q.size();
  end

endmodule

`default_nettype wire

[test/tb_lidar_gap_follow_steering_unit.sv]
// ----------------------------------------------------------------------------
// tb_lidar_gap_follow_steering_unit
// drives range samples and register settings into the gap follow unit: a
// short directed set of scans, then random scans under changing settings
// with random stalls on both channels; the checker beside the unit predicts
// every steering word and reports mismatches
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lidar_gap_follow_steering_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import lgf_pkg::*;

  localparam int RANDOM_ITEMS = 420;
  localparam int MIN_SCANS    = 20;
  localparam int CYCLE_LIMIT  = 300000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = REG_NEAR_LIMIT;
  logic [CFG_W-1:0]          cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [RANGE_W-1:0]        in_range_mm = '0;
  logic                      in_last_sample = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [STEER_W-1:0] out_steer_rate;
  logic [CENTER_W-1:0]       out_gap_center;
  logic                      out_gap_found;

  int fail_count, pending, checked;
  int tx_gap_pct = 6;
  int rx_stall_pct = 61;
  int near_cur = 500;
  int far_cur = 1000;
  int cycles = 0;
  int samples_sent = 0;
  int scans_sent = 0;
  int settings_used = 0;

  lidar_gap_follow_steering_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_range_mm    (in_range_mm),
    .in_last_sample (in_last_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_steer_rate (out_steer_rate),
    .out_gap_center (out_gap_center),
    .out_gap_found  (out_gap_found)
  );

  lgf_steer_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_range_mm    (in_range_mm),
    .in_last_sample (in_last_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_steer_rate (out_steer_rate),
    .out_gap_center (out_gap_center),
    .out_gap_found  (out_gap_found),
    .fail_count     (fail_count),
    .pending        (pending),
    .checked        (checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_lidar_gap_follow_steering_unit: done, errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin tx_gap_pct = 6;  rx_stall_pct = 61; end
      1: begin tx_gap_pct = 61; rx_stall_pct = 6;  end
      default: begin tx_gap_pct = 0; rx_stall_pct = 0; end
    endcase
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_sample(input logic [RANGE_W-1:0] r, input logic last);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_range_mm    <= r;
    in_last_sample <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
    if (last) scans_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t which, input logic [CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  task automatic program_regs(input int near, input int far, input int first_gap,
                              input int later_gap, input int deg, input int kp,
                              input int ki, input logic [CFG_W-1:0] cap);
    write_reg(REG_NEAR_LIMIT, CFG_W'(near));
    write_reg(REG_FAR_LIMIT, CFG_W'(far));
    write_reg(REG_FIRST_MIN, CFG_W'(first_gap));
    write_reg(REG_LATER_MIN, CFG_W'(later_gap));
    write_reg(REG_DEG_PER_SMP, CFG_W'(deg));
    write_reg(REG_PROP_GAIN, CFG_W'(kp));
    write_reg(REG_INT_GAIN, CFG_W'(ki));
    write_reg(REG_INT_CAP, cap);
    cfg_wr_en <= 1'b0;
    near_cur = near;
    far_cur  = far;
    settings_used++;
  endtask

  task automatic pick_setting(input int which);
    int near;
    case (which)
      0: program_regs(300, 2000, 5, 2, 16384, 167772, 1678, 31'd77);
      1: program_regs(65535, 0, 4096, 0, 65535, 24'hFFFFFF, 24'hFFFFFF, 31'h7FFFFFFF);
      2: program_regs(999, 1000, 0, 1, 0, 0, 0, 31'd0);
      3: program_regs(0, 65535, 0, 4096, 1, 1, 1, 31'd1);
      default: begin
        near = $urandom_range(0, 2000);
        program_regs(near, near + $urandom_range(2, 3000), $urandom_range(0, 8),
                     $urandom_range(0, 8), $urandom_range(0, 65535),
                     $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                     $urandom_range(0, 1) ? CFG_W'($urandom_range(0, 200000))
                                          : CFG_W'($urandom_range(0, 31'h7FFFFFFF)));
      end
    endcase
  endtask

  // free runs alternate with short obstacle stretches, with some noise samples
  task automatic send_scan(input int len, input bit with_last);
    int   left;
    bit   open_run;
    logic [RANGE_W-1:0] r;
    left = 0;
    open_run = 1'b0;
    for (int i = 0; i < len; i++) begin
      if (left == 0) begin
        open_run = !open_run;
        left = open_run ? $urandom_range(1, (len > 200) ? 300 : 12) : $urandom_range(1, 3);
      end
      left--;
      if ($urandom_range(0, 9) == 0)
        r = RANGE_W'($urandom_range(0, 65535));
      else if (open_run)
        r = $urandom_range(0, 1) ? RANGE_W'($urandom_range(0, near_cur))
                                 : RANGE_W'($urandom_range(far_cur, 65535));
      else if (far_cur > near_cur + 1)
        r = RANGE_W'($urandom_range(near_cur + 1, far_cur - 1));
      else
        r = RANGE_W'($urandom_range(0, 65535));
      send_sample(r, with_last && (i == len - 1));
    end
  endtask

  function automatic int pick_scan_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 1;
    if (roll < 85) return $urandom_range(2, 16);
    return $urandom_range(17, 80);
  endfunction

  initial begin
    int items, len, mode, setting_no;
    items = 0;
    setting_no = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    program_regs(500, 1000, 2, 1, 16384, 167772, 1678, 31'd77);

    // range extremes, both limit edges, a gap that beats the first scan bar
    send_sample(16'd0, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'd700, 1'b0);
    send_sample(16'd500, 1'b0);
    send_sample(16'd1000, 1'b0);
    send_sample(16'd999, 1'b0);
    send_sample(16'd501, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    // single sample scan
    send_sample(16'd1234, 1'b1);
    // no gap at all, center held
    send_sample(16'd0, 1'b0);
    send_sample(16'd700, 1'b0);
    send_sample(16'd800, 1'b0);
    send_sample(16'd900, 1'b1);
    // free run closed by the last sample
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd0, 1'b1);

    while (items < RANDOM_ITEMS || scans_sent < MIN_SCANS) begin
      if (setting_no == 0 || (scans_sent % 8) == 0) begin
        wait_drained();
        pick_setting(setting_no);
        setting_no++;
      end
      mode = (items * 3) / RANDOM_ITEMS;
      set_idling(mode);
      len = pick_scan_len();
      send_scan(len, 1'b1);
      items += len;
    end

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    $display("sent %0d samples in %0d scans under %0d register settings",
             samples_sent, scans_sent, settings_used);
    $display("compared %0d steering words across both stall patterns", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_lidar_gap_follow_steering_unit: done, clean");
    end else begin
      $display("tb_lidar_gap_follow_steering_unit: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
